// ===== design/dfp_pkg.sv =====
package dfp_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned ARG_W   = 32;
    localparam int unsigned DIGIT_W = 4;
    // 32-bit unsigned holds at most ten decimal digits
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned DIDX_W     = $clog2(MAX_DIGITS);

    typedef logic [CHAR_W-1:0]         t_char;
    typedef logic [ARG_W-1:0]          t_arg;
    typedef logic [DIGIT_W-1:0]        t_digit;
    typedef logic [DIDX_W-1:0]         t_didx;
    typedef logic [CHAR_W+ARG_W-1:0]   t_in_tdata;

    localparam t_char CH_ZERO    = 8'h30;
    localparam t_char CH_MINUS   = 8'h2D;
    localparam t_char CH_PERCENT = 8'h25;
    localparam t_char CH_D       = 8'h64;
    localparam t_char CH_NUL     = 8'h00;

    // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
    localparam t_arg        RECIP10     = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;
    localparam int unsigned QUO_W       = 2*ARG_W - RECIP_SHIFT;

    typedef logic [QUO_W-1:0] t_quo;

endpackage

// ===== design/decimal_format_printer.sv =====
// Channel | Dir | tdata (low bit up)                    | tlast | tuser
// s_axis  | in  | format_char[7:0], arg_value[39:8]     | -     | -
// m_axis  | out | out_char[7:0]                         | last  | error
//
// Ordinary byte and bad specifier: taken in, beat registered out; '%' is held as pending.
// %d: per digit a multiply state (reciprocal of ten) and a fix-up state, then
// the sign and digit beats are emitted, each held while m_axis stalls.
// The shared 32x32 reciprocal multiplier sets the digit loop.
// i_rst_n is synchronous, active low; clears state, pending, halted and valid.
// m_axis stalls hold output; s_axis_tready needs idle and (halted or output free).
module decimal_format_printer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  dfp_pkg::t_in_tdata  s_axis_tdata,   // format_char[7:0], arg_value[39:8]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output dfp_pkg::t_char      m_axis_tdata,   // out_char[7:0]
    output logic                m_axis_tlast,
    output logic                m_axis_tuser    // error[0]
);
    import dfp_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_pending, n_pending;
    logic       r_halted, n_halted;
    logic       r_neg, n_neg;
    t_arg       r_mag, n_mag;
    t_quo       r_quo, n_quo;
    t_didx      r_nd, n_nd;
    t_digit     r_digs [MAX_DIGITS];

    // output register
    logic       r_out_valid, n_out_valid;
    t_char      r_out_char, n_out_char;
    logic       r_out_last, n_out_last;
    logic       r_out_err, n_out_err;

    t_char      w_char;
    t_arg       w_arg;
    logic       w_in_acc;
    logic       w_out_free;
    logic [2*ARG_W-1:0] w_prod;
    t_arg       w_q10;
    t_arg       w_rem;
    logic       w_dig_we;

    assign w_char     = s_axis_tdata[CHAR_W-1:0];
    assign w_arg      = s_axis_tdata[CHAR_W+ARG_W-1:CHAR_W];
    assign w_out_free = !r_out_valid || m_axis_tready;

    // halted: accept and drop everything
    assign s_axis_tready = (r_state == S_IDLE) && (r_halted || w_out_free);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // shared divide-by-ten unit: multiply this cycle, fix-up next
    assign w_prod = {{ARG_W{1'b0}}, r_mag} * {{ARG_W{1'b0}}, RECIP10};
    assign w_q10  = {r_quo, 3'b000} + {2'b00, r_quo, 1'b0};
    assign w_rem  = r_mag - w_q10;

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_halted    = r_halted;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_quo       = r_quo;
        n_nd        = r_nd;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        w_dig_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && !r_halted) begin
                    if (r_pending) begin
                        n_pending = 1'b0;
                        if (w_char == CH_D) begin
                            n_neg   = w_arg[ARG_W-1];
                            n_mag   = w_arg[ARG_W-1] ? (t_arg'(0) - w_arg) : w_arg;
                            n_nd    = '0;
                            n_state = S_MUL;
                        end else begin
                            n_halted    = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_char  = CH_NUL;
                            n_out_last  = 1'b1;
                            n_out_err   = 1'b1;
                        end
                    end else if (w_char == CH_PERCENT) begin
                        n_pending = 1'b1;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_char  = w_char;
                        n_out_last  = 1'b1;
                        n_out_err   = 1'b0;
                    end
                end
            end
            S_MUL: begin
                n_quo   = w_prod[2*ARG_W-1:RECIP_SHIFT];
                n_state = S_FIX;
            end
            S_FIX: begin
                w_dig_we = 1'b1;
                n_mag    = {{(ARG_W-QUO_W){1'b0}}, r_quo};
                if (r_quo == '0) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end else begin
                    n_nd    = r_nd + t_didx'(1);
                    n_state = S_MUL;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_MINUS;
                    n_out_last  = 1'b0;
                    n_out_err   = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                // most significant digit sits at the highest index
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = CH_ZERO + t_char'(r_digs[r_nd]);
                    n_out_last  = (r_nd == '0);
                    n_out_err   = 1'b0;
                    if (r_nd == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_nd = r_nd - t_didx'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= 1'b0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_quo      <= n_quo;
        r_nd       <= n_nd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
        if (w_dig_we) begin
            r_digs[r_nd] <= w_rem[DIGIT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_err;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE))
        else $error("input taken while a conversion is running");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_last && r_out_char == CH_NUL))
        else $error("error beat not a lone zero beat");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> (w_rem < t_arg'(10)))
        else $error("divide-by-ten remainder out of range");

    a_no_pending_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_pending)
        else $error("percent still pending during conversion");

endmodule
